// File: rtl/clae_pkg.sv
`default_nettype none

package clae_pkg;

  localparam int DEF_MAX_SLOTS    = 1024;
  localparam int DEF_MARKER_BYTES = 4;

  localparam int SLOTS_W   = 11;
  localparam int SLOT_CAP_MAX = 2047;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_ENTRY_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_SLOTS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_ENTRY_BYTES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_SLOTS         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EEPROM_BYTES      = 3'd5;

  localparam logic [2:0] OP_READ_EVENT  = 3'd0;
  localparam logic [2:0] OP_WRITE_EVENT = 3'd1;
  localparam logic [2:0] OP_READ_LOG    = 3'd2;
  localparam logic [2:0] OP_WRITE_LOG   = 3'd3;
  localparam logic [2:0] OP_SCAN_START  = 3'd4;
  localparam logic [2:0] OP_SCAN_ENTRY  = 3'd5;
  localparam logic [2:0] OP_CLEAR_AREA  = 3'd6;

  localparam logic RING_EVENT = 1'b0;
  localparam logic RING_LOG   = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BACK_OOR = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic        area;
    logic [9:0]  back_count;
    logic [9:0]  slot;
    logic [63:0] stored_id;
  } req_t;

  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  length;
    logic [63:0] entry_id;
    logic        status;
    logic [31:0] free_address;
    logic [20:0] free_bytes;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EV_RING,
    ST_LG_RING,
    ST_MOD,
    ST_ADDR
  } state_t;

endpackage

`default_nettype wire

// File: rtl/circular_log_address_engine_top.sv
`default_nettype none

// Channel  | valid     | stall     | payload
// ---------+-----------+-----------+------------------------------
// request  | req_valid | req_stall | req (clae_pkg::req_t)
// response | rsp_valid | rsp_stall | rsp (clae_pkg::rsp_t)
// config   | cfg_we    | -         | cfg_index, cfg_data
//
// A transaction, accept to accept, runs ST_EV_RING, ST_LG_RING and ST_ADDR through one shared
// multiply-add unit (lg ring start, ring end, entry address).
// A current slot at or beyond the slot count adds the ST_MOD restoring
// remainder over the CUR_W bits of the slot, one bit per cycle.
// rst is synchronous; it loads the register defaults and zeroes slots and ids.
// A finished result waits in the output register; the next request is
// taken meanwhile and holds in the address step until the output frees.

module circular_log_address_engine_top #(
  parameter int MAX_SLOTS    = clae_pkg::DEF_MAX_SLOTS,
  parameter int MARKER_BYTES = clae_pkg::DEF_MARKER_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [clae_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [clae_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire clae_pkg::req_t                 req,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output clae_pkg::rsp_t                      rsp
);

  import clae_pkg::*;

  localparam int SLOT_CAP = (MAX_SLOTS > SLOT_CAP_MAX) ? SLOT_CAP_MAX : MAX_SLOTS;
  localparam int CUR_W    = $clog2(SLOT_CAP);
  localparam int CNT_W    = $clog2(CUR_W + 1);
  localparam logic [SLOTS_W-1:0] SLOT_CAP_V = SLOTS_W'(SLOT_CAP);
  localparam logic [31:0] MARKER_V = 32'(MARKER_BYTES);

  function automatic logic [SLOTS_W-1:0] eff_slots(input logic [SLOTS_W-1:0] n);
    logic [SLOTS_W-1:0] r;
    if (n == '0) begin
      r = SLOTS_W'(1);
    end else if (n > SLOT_CAP_V) begin
      r = SLOT_CAP_V;
    end else begin
      r = n;
    end
    return r;
  endfunction

  // configuration
  logic [31:0]        base_address;
  logic [7:0]         event_entry_bytes;
  logic [SLOTS_W-1:0] event_slots;
  logic [7:0]         log_entry_bytes;
  logic [SLOTS_W-1:0] log_slots;
  logic [20:0]        eeprom_bytes;

  // ring state
  logic [CUR_W-1:0] ev_cur, ev_cur_next;
  logic [CUR_W-1:0] lg_cur, lg_cur_next;
  logic [63:0]      ev_seq, ev_seq_next;
  logic [63:0]      lg_seq, lg_seq_next;

  // sequencer
  state_t state, state_next;
  req_t   job;
  logic   ring;
  logic   need_mod;
  logic [SLOTS_W-1:0] rem;
  logic [CUR_W-1:0]   div_sh;
  logic [CNT_W-1:0]   cnt;
  logic [31:0]        lg_start;
  logic [31:0]        free_end;

  logic [SLOTS_W-1:0] ev_eff, lg_eff;
  logic               req_ring;
  logic [CUR_W-1:0]   req_cur;
  logic [SLOTS_W-1:0] req_slots;
  logic               accept;
  logic               load;

  // shared multiply-add
  logic [31:0]         mac_add;
  logic [SLOTS_W-1:0]  mac_a;
  logic [7:0]          mac_b;
  logic [18:0]         mac_prod;
  logic [31:0]         mac_out;

  // address step
  logic [SLOTS_W-1:0] slots_sel;
  logic [7:0]         ebytes_sel;
  logic [63:0]        seq_sel;
  logic [SLOTS_W-1:0] c_inc;
  logic [SLOTS_W-1:0] c_nxt;
  logic [SLOTS_W:0]   d_wrap;
  logic [SLOTS_W-1:0] d_idx;
  logic [SLOTS_W-1:0] back_ext;
  logic [SLOTS_W-1:0] slot_ext;
  logic               back_oor;
  logic               slot_ok;
  logic               id_win;
  logic [SLOTS_W-1:0] idx;
  logic [31:0]        start_sel;
  logic [20:0]        used;
  logic [SLOTS_W:0]   mod_try;
  rsp_t               rsp_next;

  assign ev_eff = eff_slots(event_slots);
  assign lg_eff = eff_slots(log_slots);

  always_comb begin
    if (req.op == OP_READ_EVENT || req.op == OP_WRITE_EVENT) begin
      req_ring = RING_EVENT;
    end else if (req.op == OP_READ_LOG || req.op == OP_WRITE_LOG) begin
      req_ring = RING_LOG;
    end else begin
      req_ring = req.area;
    end
  end

  assign req_cur   = (req_ring == RING_LOG) ? lg_cur : ev_cur;
  assign req_slots = (req_ring == RING_LOG) ? lg_eff : ev_eff;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign load      = (state == ST_ADDR) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address      <= 32'd0;
      event_entry_bytes <= 8'd16;
      event_slots       <= SLOTS_W'(64);
      log_entry_bytes   <= 8'd16;
      log_slots         <= SLOTS_W'(64);
      eeprom_bytes      <= 21'd8192;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS:      base_address      <= cfg_data;
        REG_EVENT_ENTRY_BYTES: event_entry_bytes <= cfg_data[7:0];
        REG_EVENT_SLOTS:       event_slots       <= cfg_data[SLOTS_W-1:0];
        REG_LOG_ENTRY_BYTES:   log_entry_bytes   <= cfg_data[7:0];
        REG_LOG_SLOTS:         log_slots         <= cfg_data[SLOTS_W-1:0];
        REG_EEPROM_BYTES:      eeprom_bytes      <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  // shared unit operand select
  always_comb begin
    mac_add = start_sel;
    mac_a   = idx;
    mac_b   = ebytes_sel;
    unique case (state)
      ST_EV_RING: begin
        mac_add = base_address + MARKER_V;
        mac_a   = ev_eff;
        mac_b   = event_entry_bytes;
      end
      ST_LG_RING: begin
        mac_add = lg_start + MARKER_V;
        mac_a   = lg_eff;
        mac_b   = log_entry_bytes;
      end
      default: ;
    endcase
  end

  assign mac_prod = 19'(mac_a) * 19'(mac_b);
  assign mac_out  = mac_add + 32'(mac_prod);

  assign mod_try = {rem, div_sh[CUR_W-1]};

  // address step
  always_comb begin
    slots_sel  = (ring == RING_LOG) ? lg_eff : ev_eff;
    ebytes_sel = (ring == RING_LOG) ? log_entry_bytes : event_entry_bytes;
    seq_sel    = (ring == RING_LOG) ? lg_seq : ev_seq;
    start_sel  = (ring == RING_LOG) ? lg_start : base_address;
    c_inc      = rem + SLOTS_W'(1);
    c_nxt      = (c_inc == slots_sel) ? '0 : c_inc;
    back_ext   = SLOTS_W'(job.back_count);
    slot_ext   = SLOTS_W'(job.slot);
    back_oor   = (back_ext >= slots_sel);
    slot_ok    = (slot_ext < slots_sel);
    id_win     = (job.stored_id >= seq_sel);
    d_wrap     = {1'b0, rem} + {1'b0, slots_sel} - {1'b0, back_ext};
    d_idx      = (rem >= back_ext) ? (rem - back_ext) : d_wrap[SLOTS_W-1:0];
    used       = 21'(free_end - base_address);

    ev_cur_next = ev_cur;
    lg_cur_next = lg_cur;
    ev_seq_next = ev_seq;
    lg_seq_next = lg_seq;

    idx = '0;
    rsp_next.address  = '0;
    rsp_next.length   = '0;
    rsp_next.entry_id = '0;
    rsp_next.status   = STATUS_OK;
    rsp_next.free_address = (base_address > lg_start) ? lg_start : free_end;
    rsp_next.free_bytes   = (eeprom_bytes > used) ? (eeprom_bytes - used) : '0;

    unique case (job.op)
      OP_READ_EVENT: begin
        idx = d_idx;
        rsp_next.entry_id = seq_sel;
        if (back_oor) begin
          rsp_next.status = STATUS_BACK_OOR;
        end else begin
          rsp_next.address = mac_out;
          rsp_next.length  = ebytes_sel;
        end
      end
      OP_WRITE_EVENT, OP_WRITE_LOG: begin
        idx = c_nxt;
        rsp_next.address  = mac_out;
        rsp_next.length   = ebytes_sel;
        rsp_next.entry_id = seq_sel + 64'd1;
        if (ring == RING_LOG) begin
          lg_cur_next = CUR_W'(c_nxt);
          lg_seq_next = seq_sel + 64'd1;
        end else begin
          ev_cur_next = CUR_W'(c_nxt);
          ev_seq_next = seq_sel + 64'd1;
        end
      end
      OP_READ_LOG: begin
        idx = rem;
        rsp_next.address  = mac_out;
        rsp_next.length   = ebytes_sel;
        rsp_next.entry_id = seq_sel;
      end
      OP_SCAN_START, OP_CLEAR_AREA: begin
        idx = slots_sel;
        rsp_next.address = mac_out;
        rsp_next.length  = 8'(MARKER_BYTES);
        if (ring == RING_LOG) begin
          lg_cur_next = '0;
          lg_seq_next = '0;
        end else begin
          ev_cur_next = '0;
          ev_seq_next = '0;
        end
      end
      OP_SCAN_ENTRY: begin
        idx = slot_ext;
        rsp_next.entry_id = seq_sel;
        if (slot_ok) begin
          rsp_next.address = mac_out;
          rsp_next.length  = ebytes_sel;
          if (id_win) begin
            rsp_next.entry_id = job.stored_id;
            if (ring == RING_LOG) begin
              lg_cur_next = CUR_W'(job.slot);
              lg_seq_next = job.stored_id;
            end else begin
              ev_cur_next = CUR_W'(job.slot);
              ev_seq_next = job.stored_id;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept) state_next = ST_EV_RING;
      ST_EV_RING: state_next = ST_LG_RING;
      ST_LG_RING: state_next = need_mod ? ST_MOD : ST_ADDR;
      ST_MOD:     if (cnt == CNT_W'(1)) state_next = ST_ADDR;
      ST_ADDR:    if (load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_cur    <= '0;
      lg_cur    <= '0;
      ev_seq    <= '0;
      lg_seq    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load) begin
        ev_cur    <= ev_cur_next;
        lg_cur    <= lg_cur_next;
        ev_seq    <= ev_seq_next;
        lg_seq    <= lg_seq_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_next;
    end
  end

  // job capture, ring sums and slot remainder
  always_ff @(posedge clk) begin
    if (accept) begin
      job    <= req;
      ring   <= req_ring;
      div_sh <= req_cur;
      cnt    <= CNT_W'(CUR_W);
      if (SLOTS_W'(req_cur) < req_slots) begin
        need_mod <= 1'b0;
        rem      <= SLOTS_W'(req_cur);
      end else begin
        need_mod <= 1'b1;
        rem      <= '0;
      end
    end
    if (state == ST_EV_RING) begin
      lg_start <= mac_out;
    end
    if (state == ST_LG_RING) begin
      free_end <= mac_out;
    end
    if (state == ST_MOD) begin
      div_sh <= div_sh << 1;
      cnt    <= cnt - CNT_W'(1);
      if (mod_try >= {1'b0, slots_sel}) begin
        rem <= SLOTS_W'(mod_try - {1'b0, slots_sel});
      end else begin
        rem <= mod_try[SLOTS_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire
